[hw/rtl/rco_pkg.sv]
// Shared types and constants for the ring clock overlay pixel core.
`default_nettype none

package rco_pkg;

  localparam int unsigned PIPE_DEPTH = 13;

  localparam logic [2:0] REG_SEG_FIRST = 3'd0;
  localparam logic [2:0] REG_SEG_LAST  = 3'd1;
  localparam logic [2:0] REG_TWELVE    = 3'd2;
  localparam logic [2:0] REG_FLAGS     = 3'd3;
  localparam logic [2:0] REG_CD_TARGET = 3'd4;
  localparam logic [2:0] REG_CD_COLOR  = 3'd5;

  localparam int unsigned FLAG_TRAIL     = 0;
  localparam int unsigned FLAG_MARKS     = 1;
  localparam int unsigned FLAG_ADD       = 2;
  localparam int unsigned FLAG_COUNTDOWN = 3;

  localparam logic [31:0] COL_RED   = 32'h00FF_0000;
  localparam logic [31:0] COL_GREEN = 32'h0000_FF00;
  localparam logic [31:0] COL_BLUE  = 32'h0000_00FF;
  localparam logic [31:0] COL_MARK  = 32'h0000_FFAA;

  localparam logic [28:0] UNIT_DECADE = 29'd315576000;
  localparam logic [28:0] UNIT_YEAR   = 29'd31557600;
  localparam logic [28:0] UNIT_MONTH  = 29'd2592000;
  localparam logic [28:0] UNIT_WEEK   = 29'd604800;
  localparam logic [28:0] UNIT_DAY    = 29'd86400;
  localparam logic [28:0] UNIT_HOUR   = 29'd3600;
  localparam logic [28:0] UNIT_MINUTE = 29'd60;

  // ceil(2^k / d) reciprocals: exact floor division for x < 2^(k - ceil(log2 d))
  localparam logic [14:0] RECIP_60  = 15'd17477;   // k = 20, x < 2^14
  localparam logic [18:0] RECIP_720 = 19'd372828;  // k = 28, x < 2^18
  localparam logic [12:0] RECIP_12  = 13'd5462;    // k = 16, x < 2^12

  typedef struct packed {
    logic [7:0]  seg_first;
    logic [7:0]  seg_last;
    logic [7:0]  twelve;
    logic [3:0]  flags;
    logic [31:0] cd_target;
    logic [31:0] cd_color;
    logic [8:0]  seg_size;
  } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/rco_cfg_regs.sv]
// Configuration register file with its write channel.
`default_nettype none

module rco_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output rco_pkg::cfg_t cfg
);
  import rco_pkg::*;

  logic [7:0]  seg_first;
  logic [7:0]  seg_last;
  logic [7:0]  twelve;
  logic [3:0]  flags;
  logic [31:0] cd_target;
  logic [31:0] cd_color;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_first <= 8'd0;
      seg_last  <= 8'd59;
      twelve    <= 8'd0;
      flags     <= 4'd0;
      cd_target <= 32'd0;
      cd_color  <= 32'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SEG_FIRST: seg_first <= cfg_data[7:0];
        REG_SEG_LAST:  seg_last  <= cfg_data[7:0];
        REG_TWELVE:    twelve    <= cfg_data[7:0];
        REG_FLAGS:     flags     <= cfg_data[3:0];
        REG_CD_TARGET: cd_target <= cfg_data;
        REG_CD_COLOR:  cd_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.seg_first = seg_first;
    cfg.seg_last  = seg_last;
    cfg.twelve    = twelve;
    cfg.flags     = flags;
    cfg.cd_target = cd_target;
    cfg.cd_color  = cd_color;
    cfg.seg_size  = {1'b0, seg_last} - {1'b0, seg_first} + 9'd1;
  end

endmodule

`default_nettype wire

[hw/rtl/rco_clock_path.sv]
// Clock-face pipeline: hand and mark positions, layer hits and color compose.
`default_nettype none

module rco_clock_path (
  input  logic          clk,
  input  logic          en,
  input  rco_pkg::cfg_t cfg,
  input  logic [7:0]    pixel_index,
  input  logic [31:0]   old_color,
  input  logic [4:0]    hour_now,
  input  logic [5:0]    minute_now,
  input  logic [5:0]    second_now,
  output logic [31:0]   color,
  output logic          touched
);
  import rco_pkg::*;

  localparam int unsigned MARKS = 13;
  localparam int unsigned LINE  = PIPE_DEPTH - 5;

  typedef struct packed {
    logic [31:0] color;
    logic        touched;
  } px_t;

  function automatic logic [9:0] wrap_pos(input logic [9:0] p, input logic [7:0] last,
                                          input logic [8:0] size);
    return (p > {2'b00, last}) ? p - {1'b0, size} : p;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [8:0]  s;
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
      r[8*k +: 8] = s[8] ? 8'hFF : s[7:0];
    end
    return r;
  endfunction

  // stage 1: hour term, products with the segment size
  logic [3:0]  hmod;
  logic [11:0] mark_y [MARKS];
  logic [7:0]  s1_pix;
  logic [31:0] s1_old;
  logic [9:0]  s1_t;
  logic [13:0] s1_xm;
  logic [13:0] s1_xs;
  logic [11:0] s1_y [MARKS];

  always_comb begin
    if (hour_now >= 5'd24) begin
      hmod = 4'(hour_now - 5'd24);
    end else if (hour_now >= 5'd12) begin
      hmod = 4'(hour_now - 5'd12);
    end else begin
      hmod = hour_now[3:0];
    end
    for (int i = 0; i < MARKS; i++) begin
      mark_y[i] = 12'(12'(cfg.seg_size) * 12'(i)) + 12'd6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix <= pixel_index;
      s1_old <= old_color;
      s1_t   <= 10'(10'(hmod) * 10'd60) + 10'(minute_now);
      s1_xm  <= 14'(15'(cfg.seg_size) * 15'(minute_now));
      s1_xs  <= 14'(15'(cfg.seg_size) * 15'(second_now));
      for (int i = 0; i < MARKS; i++) begin
        s1_y[i] <= mark_y[i];
      end
    end
  end

  // stage 2: divide by 60 and 12, hour product
  logic [28:0] prod_m;
  logic [28:0] prod_s;
  logic [24:0] prod_y [MARKS];
  logic [7:0]  s2_pix;
  logic [31:0] s2_old;
  logic [17:0] s2_xh;
  logic [8:0]  s2_qm;
  logic [8:0]  s2_qs;
  logic [8:0]  s2_qy [MARKS];

  always_comb begin
    prod_m = 29'(s1_xm) * 29'(RECIP_60);
    prod_s = 29'(s1_xs) * 29'(RECIP_60);
    for (int i = 0; i < MARKS; i++) begin
      prod_y[i] = 25'(s1_y[i]) * 25'(RECIP_12);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_pix <= s1_pix;
      s2_old <= s1_old;
      s2_xh  <= 18'(19'(s1_t) * 19'(cfg.seg_size));
      s2_qm  <= prod_m[28:20];
      s2_qs  <= prod_s[28:20];
      for (int i = 0; i < MARKS; i++) begin
        s2_qy[i] <= prod_y[i][24:16];
      end
    end
  end

  // stage 3: divide hour product by 720, offset from twelve
  logic [36:0] prod_h;
  logic [7:0]  s3_pix;
  logic [31:0] s3_old;
  logic [8:0]  s3_qh;
  logic [9:0]  s3_pm;
  logic [9:0]  s3_ps;
  logic [9:0]  s3_py [MARKS];

  assign prod_h = 37'(s2_xh) * 37'(RECIP_720);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_pix <= s2_pix;
      s3_old <= s2_old;
      s3_qh  <= prod_h[36:28];
      s3_pm  <= 10'(cfg.twelve) + 10'(s2_qm);
      s3_ps  <= 10'(cfg.twelve) + 10'(s2_qs);
      for (int i = 0; i < MARKS; i++) begin
        s3_py[i] <= 10'(cfg.twelve) + 10'(s2_qy[i]);
      end
    end
  end

  // stage 4: hour offset from twelve; wrap minute, second and marks
  logic [7:0]  s4_pix;
  logic [31:0] s4_old;
  logic [9:0]  s4_ph;
  logic [9:0]  s4_pm;
  logic [9:0]  s4_ps;
  logic [9:0]  s4_py [MARKS];

  always_ff @(posedge clk) begin
    if (en) begin
      s4_pix <= s3_pix;
      s4_old <= s3_old;
      s4_ph  <= 10'(cfg.twelve) + 10'(s3_qh);
      s4_pm  <= wrap_pos(s3_pm, cfg.seg_last, cfg.seg_size);
      s4_ps  <= wrap_pos(s3_ps, cfg.seg_last, cfg.seg_size);
      for (int i = 0; i < MARKS; i++) begin
        s4_py[i] <= wrap_pos(s3_py[i], cfg.seg_last, cfg.seg_size);
      end
    end
  end

  // stage 5: wrap hour, layer hits
  logic [9:0]  pix10;
  logic [9:0]  ph;
  logic [9:0]  c12;
  logic [9:0]  first10;
  logic [9:0]  last10;
  logic        trail_hit;
  logic        mark_hit;
  logic [31:0] s5_old;
  logic        s5_trail;
  logic        s5_mark;
  logic        s5_s;
  logic        s5_m;
  logic        s5_h;

  always_comb begin
    pix10   = 10'(s4_pix);
    c12     = 10'(cfg.twelve);
    first10 = 10'(cfg.seg_first);
    last10  = 10'(cfg.seg_last);
    ph      = wrap_pos(s4_ph, cfg.seg_last, cfg.seg_size);
    if (s4_ps < c12) begin
      trail_hit = (pix10 >= c12 && pix10 <= last10) || (pix10 >= first10 && pix10 <= s4_ps);
    end else begin
      trail_hit = pix10 >= c12 && pix10 <= s4_ps;
    end
    mark_hit = 1'b0;
    for (int i = 0; i < MARKS; i++) begin
      mark_hit = mark_hit | (s4_py[i] == pix10);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_old   <= s4_old;
      s5_trail <= trail_hit;
      s5_mark  <= mark_hit;
      s5_s     <= s4_ps == pix10;
      s5_m     <= s4_pm == pix10;
      s5_h     <= ph == pix10;
    end
  end

  // stage 6: compose layers, then delay line to match the countdown path
  px_t comp;
  px_t line [LINE];

  always_comb begin
    comp.color   = s5_old;
    comp.touched = 1'b0;
    if (cfg.flags[FLAG_TRAIL] && s5_trail) begin
      comp.color   = COL_RED;
      comp.touched = 1'b1;
    end
    if (cfg.flags[FLAG_MARKS] && s5_mark) begin
      comp.color   = COL_MARK;
      comp.touched = 1'b1;
    end
    if (!cfg.flags[FLAG_TRAIL] && s5_s) begin
      comp.color   = cfg.flags[FLAG_ADD] ? sat_add(comp.color, COL_RED) : COL_RED;
      comp.touched = 1'b1;
    end
    if (s5_m) begin
      comp.color   = cfg.flags[FLAG_ADD] ? sat_add(comp.color, COL_GREEN) : COL_GREEN;
      comp.touched = 1'b1;
    end
    if (s5_h) begin
      comp.color   = cfg.flags[FLAG_ADD] ? sat_add(comp.color, COL_BLUE) : COL_BLUE;
      comp.touched = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= comp;
      for (int k = 1; k < LINE; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign color   = line[LINE-1].color;
  assign touched = line[LINE-1].touched;

endmodule

`default_nettype wire

[hw/rtl/rco_countdown_path.sv]
// Countdown pipeline: unit select, elapsed product, restoring divider, arc hit.
`default_nettype none

module rco_countdown_path (
  input  logic          clk,
  input  logic          en,
  input  rco_pkg::cfg_t cfg,
  input  logic [7:0]    pixel_index,
  input  logic [31:0]   epoch_now,
  output logic          hit
);
  import rco_pkg::*;

  localparam int unsigned DIV_STEPS = 8;

  typedef struct packed {
    logic [36:0] rem;
    logic [7:0]  quo;
    logic [28:0] unit;
    logic        live;
    logic [7:0]  pix;
  } div_t;

  // stage 1: time remaining
  logic        s1_live;
  logic [31:0] s1_diff;
  logic [7:0]  s1_pix;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_live <= epoch_now < cfg.cd_target;
      s1_diff <= cfg.cd_target - epoch_now;
      s1_pix  <= pixel_index;
    end
  end

  // stage 2: unit select
  logic [28:0] unit;
  logic        s2_live;
  logic [31:0] s2_diff;
  logic [28:0] s2_unit;
  logic [7:0]  s2_pix;

  always_comb begin
    if (s1_diff > 32'(UNIT_YEAR)) begin
      unit = UNIT_DECADE;
    end else if (s1_diff > 32'(UNIT_MONTH)) begin
      unit = UNIT_YEAR;
    end else if (s1_diff > 32'(UNIT_WEEK)) begin
      unit = UNIT_MONTH;
    end else if (s1_diff > 32'(UNIT_DAY)) begin
      unit = UNIT_WEEK;
    end else if (s1_diff > 32'(UNIT_HOUR)) begin
      unit = UNIT_DAY;
    end else if (s1_diff > 32'(UNIT_MINUTE)) begin
      unit = UNIT_HOUR;
    end else begin
      unit = UNIT_MINUTE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_live <= s1_live;
      s2_diff <= s1_diff;
      s2_unit <= unit;
      s2_pix  <= s1_pix;
    end
  end

  // stage 3: elapsed part of the unit, clamped at zero
  logic [32:0] elapsed;
  logic        s3_live;
  logic [28:0] s3_e;
  logic [28:0] s3_unit;
  logic [7:0]  s3_pix;

  assign elapsed = 33'(s2_unit) - 33'(s2_diff);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_live <= s2_live;
      s3_e    <= elapsed[32] ? 29'd0 : elapsed[28:0];
      s3_unit <= s2_unit;
      s3_pix  <= s2_pix;
    end
  end

  // stage 4: scale by segment size
  div_t dv [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].rem  <= 37'(s3_e) * 37'(cfg.seg_size);
      dv[0].quo  <= '0;
      dv[0].unit <= s3_unit;
      dv[0].live <= s3_live;
      dv[0].pix  <= s3_pix;
    end
  end

  // stages 5 to 12: one quotient bit per stage, most significant first
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int unsigned BIT = DIV_STEPS - 1 - k;
    logic [36:0] dvsr;
    div_t        nxt;

    always_comb begin
      dvsr = 37'(dv[k].unit) << BIT;
      nxt  = dv[k];
      if (dv[k].rem >= dvsr) begin
        nxt.rem      = dv[k].rem - dvsr;
        nxt.quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= nxt;
      end
    end
  end

  // stage 13: inclusive wrapped arc from twelve
  logic [9:0] pix10;
  logic [9:0] c12;
  logic [9:0] first10;
  logic [9:0] last10;
  logic [9:0] arc_end;
  logic [9:0] end2;
  logic       arc_hit;
  logic       s13_hit;

  always_comb begin
    pix10   = 10'(dv[DIV_STEPS].pix);
    c12     = 10'(cfg.twelve);
    first10 = 10'(cfg.seg_first);
    last10  = 10'(cfg.seg_last);
    arc_end = c12 + 10'(dv[DIV_STEPS].quo);
    end2    = first10 + 10'(dv[DIV_STEPS].quo) + c12 - last10 - 10'd1;
    if (arc_end > last10) begin
      arc_hit = (pix10 >= c12 && pix10 <= last10) || (pix10 >= first10 && pix10 <= end2);
    end else begin
      arc_hit = pix10 >= c12 && pix10 <= arc_end;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s13_hit <= dv[DIV_STEPS].live && arc_hit;
    end
  end

  assign hit = s13_hit;

endmodule

`default_nettype wire

[hw/rtl/ring_clock_overlay_pixel_core.sv]
// Ring clock overlay pixel core: top level with pipeline control and output skid.
//
// Usage: one pixel per transaction on the input channel (index, present WRGB color and
// the time); one result per pixel on the output channel (new color and a touched flag),
// in input order. Registers are written through the cfg channel, which is always ready;
// write them only while no pixel is in flight.
// Throughput: one pixel per clock cycle, sustained while the output is not held.
// Each result passes through the pipeline registers and then the output register.
// The depth is set by the countdown path: unit select, a 29x9 multiply and an 8-stage
// restoring divider that yields one arc-length bit per stage; the clock-face path
// is delay-matched to it.
// Reset clears all valid bits, including the output and skid flags, and loads the
// register defaults (segment 0..59, twelve at 0, clock mode, all options off).
// Receiver stall: a one-entry skid register takes the result that arrives while the
// output is held; while it is full the whole pipeline holds and in_ready is low.
`default_nettype none

module ring_clock_overlay_pixel_core #(
  parameter int unsigned PIXEL_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel_index,
  input  logic [31:0] old_color,
  input  logic [4:0]  hour_now,
  input  logic [5:0]  minute_now,
  input  logic [5:0]  second_now,
  input  logic [31:0] epoch_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] new_color,
  output logic        touched,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rco_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [31:0] old;
  } tag_t;

  cfg_t                  cfg;
  logic                  advance;
  logic                  ok_in;
  logic [PIPE_DEPTH-1:0] pipe_valid;
  tag_t                  pipe_tag [PIPE_DEPTH];
  tag_t                  tail;
  logic [31:0]           clk_color;
  logic                  clk_touched;
  logic                  cd_hit;
  logic [31:0]           res_color;
  logic                  res_touched;
  logic                  skid_valid;
  logic [31:0]           skid_color;
  logic                  skid_touched;

  rco_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = !skid_valid;
  assign in_ready = advance;

  assign ok_in = (cfg.seg_last >= cfg.seg_first) && (cfg.twelve >= cfg.seg_first)
              && (cfg.twelve <= cfg.seg_last) && (9'(pixel_index) < 9'(PIXEL_COUNT));

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= '0;
    end else if (advance) begin
      pipe_valid <= {pipe_valid[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pipe_tag[0].ok  <= ok_in;
      pipe_tag[0].old <= old_color;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        pipe_tag[k] <= pipe_tag[k-1];
      end
    end
  end

  rco_clock_path u_clock (
    .clk         (clk),
    .en          (advance),
    .cfg         (cfg),
    .pixel_index (pixel_index),
    .old_color   (old_color),
    .hour_now    (hour_now),
    .minute_now  (minute_now),
    .second_now  (second_now),
    .color       (clk_color),
    .touched     (clk_touched)
  );

  rco_countdown_path u_countdown (
    .clk         (clk),
    .en          (advance),
    .cfg         (cfg),
    .pixel_index (pixel_index),
    .epoch_now   (epoch_now),
    .hit         (cd_hit)
  );

  assign tail = pipe_tag[PIPE_DEPTH-1];

  always_comb begin
    res_color   = tail.old;
    res_touched = 1'b0;
    if (tail.ok) begin
      if (cfg.flags[FLAG_COUNTDOWN]) begin
        if (cd_hit) begin
          res_color   = cfg.cd_color;
          res_touched = 1'b1;
        end
      end else begin
        res_color   = clk_color;
        res_touched = clk_touched;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= pipe_valid[PIPE_DEPTH-1];
      end
    end else if (!skid_valid && pipe_valid[PIPE_DEPTH-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        new_color <= skid_color;
        touched   <= skid_touched;
      end else begin
        new_color <= res_color;
        touched   <= res_touched;
      end
    end
    if (out_valid && !out_ready && !skid_valid) begin
      skid_color   <= res_color;
      skid_touched <= res_touched;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a transaction while the output register is empty");

  a_skid_load_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !out_ready))
    else $error("skid loaded without an output stall");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && out_ready) |=> (out_valid && !skid_valid))
    else $error("skid did not move into the output register");

  a_pipe_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> $stable(pipe_valid))
    else $error("pipeline advanced while the skid was full");

endmodule

`default_nettype wire

[dv/tb_ring_clock_overlay_pixel_core.sv]
// Self-checking testbench for the ring clock overlay pixel core: random and directed pixels.
`default_nettype none

module tb_ring_clock_overlay_pixel_core;
  import rco_pkg::*;

  localparam int unsigned PIXEL_COUNT = 256;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int unsigned RX_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  pixel;
    logic [31:0] color;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] epoch;
  } pixel_req_t;

  typedef struct packed {
    logic [31:0] color;
    logic        touched;
  } pixel_paint_t;

  typedef struct packed {
    logic [7:0]  seg_lo;
    logic [7:0]  seg_hi;
    logic [7:0]  twelve;
    logic [3:0]  flags;
    logic [31:0] target;
    logic [31:0] arc_color;
  } face_cfg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  pixel_index = '0;
  logic [31:0] old_color = '0;
  logic [4:0]  hour_now = '0;
  logic [5:0]  minute_now = '0;
  logic [5:0]  second_now = '0;
  logic [31:0] epoch_now = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] new_color;
  logic        touched;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pixel_req_t   pixel_feed_q[$];
  pixel_paint_t painted_q[$];
  pixel_req_t   tx_cur;
  pixel_paint_t rx_want;
  face_cfg_t    face;
  int unsigned  tx_idle_pct = 20;
  int unsigned  rx_idle_pct = 71;
  int unsigned  rx_hold_req = 0;
  int unsigned  rx_hold_ack = 0;
  int unsigned  rx_hold_left = 0;
  int unsigned  errors = 0;

  ring_clock_overlay_pixel_core #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_index(pixel_index),
    .old_color(old_color),
    .hour_now(hour_now),
    .minute_now(minute_now),
    .second_now(second_now),
    .epoch_now(epoch_now),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .new_color(new_color),
    .touched(touched),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    logic [8:0]  s;
    int unsigned k;
    r = '0;
    for (k = 0; k < 4; k++) begin
      s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
      r[8*k +: 8] = s[8] ? 8'hFF : s[7:0];
    end
    return r;
  endfunction

  function automatic logic between(input int unsigned p, input int unsigned lo,
                                   input int unsigned hi);
    return (lo <= p) && (p <= hi);
  endfunction

  function automatic int unsigned fold_pos(input int unsigned p, input int unsigned size,
                                           input int unsigned hi);
    return (p > hi) ? p - size : p;
  endfunction

  function automatic logic [31:0] hand_paint(input logic [31:0] cur, input logic [31:0] hand,
                                             input logic [3:0] flags);
    return flags[FLAG_ADD] ? add_sat(cur, hand) : hand;
  endfunction

  function automatic pixel_paint_t paint_pixel(input pixel_req_t rq, input face_cfg_t c);
    pixel_paint_t      res;
    int unsigned       lo, hi, c12, pix, size, hr, mn, sc;
    int unsigned       hpos, mpos, spos, mp, diff, unit, cnt, end2, i;
    longint unsigned   prod;
    logic              hit;
    res.color = rq.color;
    res.touched = 1'b0;
    lo = c.seg_lo;
    hi = c.seg_hi;
    c12 = c.twelve;
    pix = rq.pixel;
    hr = rq.hour;
    mn = rq.minute;
    sc = rq.second;
    if (hi >= lo && between(c12, lo, hi) && pix < PIXEL_COUNT) begin
      size = hi - lo + 1;
      if (c.flags[FLAG_COUNTDOWN]) begin
        if (rq.epoch < c.target) begin
          diff = c.target - rq.epoch;
          if (diff > UNIT_YEAR) unit = UNIT_DECADE;
          else if (diff > UNIT_MONTH) unit = UNIT_YEAR;
          else if (diff > UNIT_WEEK) unit = UNIT_MONTH;
          else if (diff > UNIT_DAY) unit = UNIT_WEEK;
          else if (diff > UNIT_HOUR) unit = UNIT_DAY;
          else if (diff > UNIT_MINUTE) unit = UNIT_HOUR;
          else unit = UNIT_MINUTE;
          cnt = 0;
          if (diff < unit) begin
            prod = longint'(unit - diff) * longint'(size);
            cnt = int'(prod / longint'(unit));
          end
          if (c12 + cnt > hi) begin
            end2 = lo + cnt - (1 + hi - c12);
            hit = between(pix, c12, hi) || between(pix, lo, end2);
          end else begin
            hit = between(pix, c12, c12 + cnt);
          end
          if (hit) begin
            res.color = c.arc_color;
            res.touched = 1'b1;
          end
        end
      end else begin
        hpos = fold_pos(c12 + (size * (60 * (hr % 12) + mn)) / 720, size, hi);
        mpos = fold_pos(c12 + (size * mn) / 60, size, hi);
        spos = fold_pos(c12 + (size * sc) / 60, size, hi);
        if (c.flags[FLAG_TRAIL]) begin
          if (spos < c12) hit = between(pix, c12, hi) || between(pix, lo, spos);
          else hit = between(pix, c12, spos);
          if (hit) begin
            res.color = COL_RED;
            res.touched = 1'b1;
          end
        end
        if (c.flags[FLAG_MARKS]) begin
          for (i = 0; i <= 12; i++) begin
            mp = fold_pos(c12 + (size * i + 6) / 12, size, hi);
            if (mp == pix) begin
              res.color = COL_MARK;
              res.touched = 1'b1;
            end
          end
        end
        if (!c.flags[FLAG_TRAIL] && spos == pix) begin
          res.color = hand_paint(res.color, COL_RED, c.flags);
          res.touched = 1'b1;
        end
        if (mpos == pix) begin
          res.color = hand_paint(res.color, COL_GREEN, c.flags);
          res.touched = 1'b1;
        end
        if (hpos == pix) begin
          res.color = hand_paint(res.color, COL_BLUE, c.flags);
          res.touched = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic face_cfg_t mk_face(input int unsigned lo, input int unsigned hi,
                                        input int unsigned tw, input logic [3:0] flags,
                                        input logic [31:0] target, input logic [31:0] arc);
    face_cfg_t c;
    c.seg_lo = 8'(lo);
    c.seg_hi = 8'(hi);
    c.twelve = 8'(tw);
    c.flags = flags;
    c.target = target;
    c.arc_color = arc;
    return c;
  endfunction

  function automatic pixel_req_t mk_item(input logic [7:0] pix, input logic [31:0] color,
                                         input logic [4:0] hr, input logic [5:0] mn,
                                         input logic [5:0] sc, input logic [31:0] epoch);
    pixel_req_t rq;
    rq.pixel = pix;
    rq.color = color;
    rq.hour = hr;
    rq.minute = mn;
    rq.second = sc;
    rq.epoch = epoch;
    return rq;
  endfunction

  function automatic int unsigned unit_bound(input int unsigned k);
    case (k)
      0: return UNIT_MINUTE;
      1: return UNIT_HOUR;
      2: return UNIT_DAY;
      3: return UNIT_WEEK;
      4: return UNIT_MONTH;
      5: return UNIT_YEAR;
      default: return UNIT_DECADE;
    endcase
  endfunction

  function automatic logic [31:0] pick_epoch(input face_cfg_t c);
    int unsigned k, lo, hi, diff;
    k = $urandom_range(8);
    if (k == 8) return c.target + $urandom_range(1000);
    if (k == 7) begin
      diff = $urandom;
    end else begin
      hi = unit_bound(k);
      lo = (k == 0) ? 1 : unit_bound(k - 1) + 1;
      case ($urandom_range(3))
        0: diff = hi;
        1: diff = lo;
        default: diff = $urandom_range(hi, lo);
      endcase
    end
    return c.target - diff;
  endfunction

  function automatic face_cfg_t pick_face(input int unsigned kind);
    int unsigned lo, hi, tw, span;
    logic [3:0]  flags;
    logic [31:0] target, arc;
    lo = 0;
    hi = 59;
    tw = $urandom_range(59);
    flags = 4'($urandom_range(7));
    target = $urandom;
    arc = $urandom;
    case (kind)
      1: begin
        hi = 255;
        tw = $urandom_range(3) == 0 ? 255 : $urandom_range(255);
      end
      2, 3: begin
        span = (kind == 2) ? $urandom_range(19, 11) : $urandom_range(99, 11);
        lo = $urandom_range(255 - span);
        hi = lo + span;
        tw = $urandom_range(hi, lo);
        if (kind == 3) flags[FLAG_COUNTDOWN] = 1'b1;
      end
      4: begin
        hi = 255;
        tw = 255;
        flags = 4'hF;
        target = 32'hFFFF_FFFF;
        arc = 32'hFFFF_FFFF;
      end
      5: begin
        flags = 4'($urandom_range(15));
        if ($urandom_range(1) != 0) begin
          lo = $urandom_range(255, 1);
          hi = $urandom_range(lo - 1);
          tw = $urandom_range(255);
        end else begin
          lo = 20;
          hi = 80;
          tw = $urandom_range(1) != 0 ? $urandom_range(19) : $urandom_range(255, 81);
        end
      end
      6: begin
        lo = $urandom_range(1) != 0 ? 255 : $urandom_range(255);
        hi = lo;
        tw = lo;
        flags = 4'($urandom_range(15));
        if ($urandom_range(1) != 0) target = 32'h0;
      end
      7: begin
        lo = $urandom_range(255);
        hi = $urandom_range(255);
        if (lo > hi) begin
          span = lo;
          lo = hi;
          hi = span;
        end
        tw = $urandom_range(hi, lo);
        flags = 4'($urandom_range(15));
      end
      default: ;
    endcase
    return mk_face(lo, hi, tw, flags, target, arc);
  endfunction

  function automatic pixel_req_t pick_pixel(input face_cfg_t c);
    pixel_req_t rq;
    if ($urandom_range(99) < 80 && c.seg_lo <= c.seg_hi)
      rq.pixel = 8'($urandom_range(c.seg_hi, c.seg_lo));
    else
      rq.pixel = 8'($urandom);
    case ($urandom_range(7))
      0: rq.color = 32'h0;
      1: rq.color = 32'hFFFF_FFFF;
      2: rq.color = 32'hF0F0_F0F0 | 32'($urandom);
      default: rq.color = $urandom;
    endcase
    rq.hour = 5'($urandom_range(9) == 0 ? $urandom_range(31) : $urandom_range(23));
    rq.minute = 6'($urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(59));
    rq.second = 6'($urandom_range(9) == 0 ? $urandom_range(63) : $urandom_range(59));
    rq.epoch = c.flags[FLAG_COUNTDOWN] ? pick_epoch(c) : 32'($urandom);
    return rq;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_face(input face_cfg_t c);
    write_reg(REG_SEG_FIRST, {24'($urandom), c.seg_lo});
    write_reg(REG_SEG_LAST, {24'($urandom), c.seg_hi});
    write_reg(REG_TWELVE, {24'($urandom), c.twelve});
    write_reg(REG_FLAGS, {28'($urandom), c.flags});
    write_reg(REG_CD_TARGET, c.target);
    write_reg(REG_CD_COLOR, c.arc_color);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pixel_feed_q.size() != 0 || in_valid || painted_q.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      face <= mk_face(0, 59, 0, 4'h0, 32'h0, 32'h0);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEG_FIRST: face.seg_lo <= cfg_data[7:0];
        REG_SEG_LAST:  face.seg_hi <= cfg_data[7:0];
        REG_TWELVE:    face.twelve <= cfg_data[7:0];
        REG_FLAGS:     face.flags <= cfg_data[3:0];
        REG_CD_TARGET: face.target <= cfg_data;
        REG_CD_COLOR:  face.arc_color <= cfg_data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) painted_q.push_back(paint_pixel(tx_cur, face));
      if (!in_valid || in_ready) begin
        if (pixel_feed_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          tx_cur = pixel_feed_q.pop_front();
          pixel_index <= tx_cur.pixel;
          old_color <= tx_cur.color;
          hour_now <= tx_cur.hour;
          minute_now <= tx_cur.minute;
          second_now <= tx_cur.second;
          epoch_now <= tx_cur.epoch;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (painted_q.size() == 0) begin
          $error("new_color %h arrived with no result expected", new_color);
          errors++;
        end else begin
          rx_want = painted_q.pop_front();
          if (new_color !== rx_want.color) begin
            $error("new_color expected %h actual %h", rx_want.color, new_color);
            errors++;
          end
          if (touched !== rx_want.touched) begin
            $error("touched expected %b actual %b", rx_want.touched, touched);
            errors++;
          end
        end
      end
      if (rx_hold_ack != rx_hold_req) begin
        rx_hold_ack = rx_hold_req;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    face_cfg_t   cur;
    int unsigned phase, n;
    logic [31:0] tgt;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // register defaults after reset: segment 0..59, twelve at 0, replace hands
    pixel_feed_q.push_back(mk_item(8'd0, 32'h0, 5'd0, 6'd0, 6'd0, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd255, 32'hFFFF_FFFF, 5'd23, 6'd59, 6'd59, 32'hFFFF_FFFF));
    pixel_feed_q.push_back(mk_item(8'd59, 32'h1234_5678, 5'd23, 6'd59, 6'd59, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd3, 32'h8765_4321, 5'd31, 6'd63, 6'd63, 32'h1));
    pixel_feed_q.push_back(mk_item(8'd35, 32'hA5A5_A5A5, 5'd7, 6'd0, 6'd0, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd60, 32'h0F0F_0F0F, 5'd0, 6'd0, 6'd60, 32'h0));

    wait_drained();
    write_face(mk_face(0, 59, 30, 4'((1 << FLAG_MARKS) | (1 << FLAG_ADD)), 32'h0, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd30, 32'h8080_8080, 5'd0, 6'd0, 6'd0, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd35, 32'hFFFF_FFFF, 5'd0, 6'd10, 6'd10, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd40, 32'h01FF_01FF, 5'd2, 6'd10, 6'd10, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd0, 32'hFFFF_FFFF, 5'd6, 6'd30, 6'd30, 32'h0));

    wait_drained();
    write_face(mk_face(10, 69, 40, 4'(1 << FLAG_TRAIL), 32'h0, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd50, 32'h1111_1111, 5'd0, 6'd0, 6'd20, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd15, 32'h2222_2222, 5'd0, 6'd0, 6'd50, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd35, 32'h3333_3333, 5'd0, 6'd0, 6'd50, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd40, 32'h4444_4444, 5'd0, 6'd0, 6'd0, 32'h0));

    wait_drained();
    tgt = 32'h0010_0000;
    write_face(mk_face(0, 59, 50, 4'(1 << FLAG_COUNTDOWN), tgt, 32'hA5A5_A5A5));
    pixel_feed_q.push_back(mk_item(8'd50, 32'h0, 5'd0, 6'd0, 6'd0, tgt));
    pixel_feed_q.push_back(mk_item(8'd50, 32'h0, 5'd0, 6'd0, 6'd0, tgt + 32'd1));
    pixel_feed_q.push_back(mk_item(8'd50, 32'h0, 5'd0, 6'd0, 6'd0, tgt - 32'd60));
    pixel_feed_q.push_back(mk_item(8'd48, 32'h0, 5'd0, 6'd0, 6'd0, tgt - 32'd61));
    pixel_feed_q.push_back(mk_item(8'd49, 32'h0, 5'd0, 6'd0, 6'd0, tgt - 32'd61));

    wait_drained();
    tgt = 32'hF000_0000;
    write_face(mk_face(100, 255, 255, 4'hF, tgt, 32'hFFFF_FFFF));
    pixel_feed_q.push_back(mk_item(8'd255, 32'h0, 5'd0, 6'd0, 6'd0, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd100, 32'h0, 5'd0, 6'd0, 6'd0, tgt - 32'd31557601));
    pixel_feed_q.push_back(mk_item(8'd254, 32'h0, 5'd0, 6'd0, 6'd0, tgt - 32'd1));

    wait_drained();
    write_face(mk_face(50, 40, 45, 4'h0, 32'h0, 32'h0));
    pixel_feed_q.push_back(mk_item(8'd45, 32'h5555_5555, 5'd0, 6'd0, 6'd0, 32'h0));

    wait_drained();
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    cfg_valid <= 1'b0;

    for (phase = 0; phase < 16; phase++) begin
      wait_drained();
      if (phase < 6) begin
        tx_idle_pct = 20;
        rx_idle_pct = 71;
      end else if (phase < 11) begin
        tx_idle_pct = 71;
        rx_idle_pct = 20;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      cur = pick_face(phase % 8);
      write_face(cur);
      if (phase == 12) rx_hold_req++;
      for (n = 0; n < 100; n++) begin
        if (phase == 13 && n == 50) wait_drained();
        pixel_feed_q.push_back(pick_pixel(cur));
      end
    end

    wait_drained();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (painted_q.size() != 0) begin
      $error("%0d expected results never arrived", painted_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
